// ===== design/sbfd_pkg.sv =====
// Shared constants for the SBUS frame decoder with PWM compare output.
// No dependencies; imported by the top level and the testbench.
package sbfd_pkg;

    localparam int FRAME_BYTES  = 25;
    localparam int IDX_W        = $clog2(FRAME_BYTES);
    localparam int CHAN_W       = 11;
    localparam int CHAN_COUNT   = 7;
    localparam int CHAN_BITS    = CHAN_W * CHAN_COUNT;
    localparam int CELL_COUNT   = (CHAN_BITS + 7) / 8;
    localparam int GAIN_W       = 16;
    localparam int OFFSET_W     = 16;
    localparam int PWM_W        = 16;
    localparam int PROD_W       = CHAN_W + GAIN_W;
    localparam int FRAC_BITS    = 12;
    localparam int OUT_W        = ((CHAN_BITS + PWM_W + 7) / 8) * 8;
    localparam int CFG_IDX_W    = 2;

    localparam logic [7:0]          START_CODE   = 8'h0F;
    localparam logic [3:0]          END_NIBBLE   = 4'h4;
    localparam logic [GAIN_W-1:0]   GAIN_RESET   = 16'd10752;
    localparam logic [OFFSET_W-1:0] OFFSET_RESET = 16'd3695;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DUTY_GAIN    = 2'd0,
        REG_PULSE_OFFSET = 2'd1
    } t_cfg_reg;

endpackage

// ===== design/sbfd_cell.sv =====
// One byte cell of the frame shift chain.
// Depends on nothing outside this file.
module sbfd_cell (
    input  logic       i_clk,
    input  logic       i_shift,
    input  logic [7:0] i_byte,
    output logic [7:0] o_byte
);

    logic [7:0] r_byte;
    logic [7:0] n_byte;

    always_comb begin
        n_byte = i_shift ? i_byte : r_byte;
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

    assign o_byte = r_byte;

endmodule

// ===== design/sbus_frame_decoder_to_pwm_top.sv =====
// Top level of the SBUS frame decoder: framer, byte cell chain, and PWM scaling pipeline.
// Depends on sbfd_pkg and sbfd_cell.
//
// Channel   Direction  Payload (low bit first)
// s_axis    in         tdata: rx_byte[7:0]
// m_axis    out        tdata: chan0..chan6 (11 bits each), pwm_compare[15:0], 3 zero bits
// cfg       in         index: register number, data: 16-bit register value
//
// One byte is taken every cycle. Results pass the multiplier stage, then the output register.
// The multiplier stage and the output register form two result slots; the input stalls only on
// the last byte of a frame while both slots are full and the output result is not taken.
// Synchronous active-low reset clears the framer, the result valid flags and the registers to
// their defaults. The config port never stalls.
module sbus_frame_decoder_to_pwm_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  logic [7:0]                           i_s_axis_tdata,   // rx_byte
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    output logic [sbfd_pkg::OUT_W-1:0]           o_m_axis_tdata,   // chan0..chan6, pwm_compare
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [sbfd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [15:0]                          i_cfg_data
);
    import sbfd_pkg::*;

    logic [GAIN_W-1:0]    r_gain;
    logic [OFFSET_W-1:0]  r_offset;
    logic [IDX_W-1:0]     r_byte_index, n_byte_index;
    logic                 r_in_frame, n_in_frame;
    logic                 r_s1_valid, n_s1_valid;
    logic [CHAN_BITS-1:0] r_s1_chans;
    logic [PROD_W-1:0]    r_s1_prod;
    logic                 r_out_valid, n_out_valid;
    logic [CHAN_BITS-1:0] r_out_chans;
    logic [PWM_W-1:0]     r_out_pwm;

    logic                 w_in_acc;
    logic                 w_last_pos;
    logic                 w_out_load;
    logic                 w_s1_free;
    logic                 w_shift;
    logic                 w_frame_done;
    logic [7:0]           w_chain [CELL_COUNT+1];
    logic [CELL_COUNT*8-1:0] w_window;
    logic [CHAN_W-1:0]    w_chan0;
    logic [PWM_W:0]       w_sum;
    logic [PWM_W-1:0]     w_pwm;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain   <= GAIN_RESET;
            r_offset <= OFFSET_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_DUTY_GAIN:    r_gain   <= i_cfg_data;
                REG_PULSE_OFFSET: r_offset <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Handshake and framer.
    assign w_last_pos = r_in_frame && (r_byte_index == IDX_W'(FRAME_BYTES - 1));
    assign w_out_load = !r_out_valid || i_m_axis_tready;
    assign w_s1_free  = !r_s1_valid || w_out_load;
    assign o_s_axis_tready = !w_last_pos || w_s1_free;
    assign w_in_acc   = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        n_in_frame   = r_in_frame;
        n_byte_index = r_byte_index;
        if (w_in_acc) begin
            if (!r_in_frame) begin
                if (i_s_axis_tdata == START_CODE) begin
                    n_in_frame   = 1'b1;
                    n_byte_index = IDX_W'(1);
                end
            end else if (w_last_pos) begin
                n_in_frame   = 1'b0;
                n_byte_index = '0;
            end else begin
                n_byte_index = r_byte_index + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame   <= 1'b0;
            r_byte_index <= '0;
        end else begin
            r_in_frame   <= n_in_frame;
            r_byte_index <= n_byte_index;
        end
    end

    // Byte cell chain holding frame bytes 1 through CELL_COUNT.
    assign w_shift = w_in_acc && r_in_frame && (r_byte_index != '0)
                     && (r_byte_index <= IDX_W'(CELL_COUNT));
    assign w_chain[CELL_COUNT] = i_s_axis_tdata;

    genvar g;
    generate
        for (g = 0; g < CELL_COUNT; g++) begin : g_cell
            sbfd_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (w_shift),
                .i_byte  (w_chain[g+1]),
                .o_byte  (w_chain[g])
            );
            assign w_window[8*g +: 8] = w_chain[g];
        end
    endgenerate

    assign w_chan0      = w_window[CHAN_W-1:0];
    assign w_frame_done = w_in_acc && w_last_pos && (i_s_axis_tdata[3:0] == END_NIBBLE);

    // Stage one: channels and gain product.
    always_comb begin
        n_s1_valid = r_s1_valid;
        if (w_frame_done) begin
            n_s1_valid = 1'b1;
        end else if (w_out_load) begin
            n_s1_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
        if (w_frame_done) begin
            r_s1_chans <= w_window[CHAN_BITS-1:0];
            r_s1_prod  <= PROD_W'(w_chan0) * PROD_W'(r_gain);
        end
    end

    // Stage two: offset add with saturation into the output register.
    assign w_sum = (PWM_W+1)'(r_offset) + (PWM_W+1)'(r_s1_prod[PROD_W-1:FRAC_BITS]);
    assign w_pwm = w_sum[PWM_W] ? {PWM_W{1'b1}} : w_sum[PWM_W-1:0];

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_out_load) begin
            n_out_valid = r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
        if (w_out_load && r_s1_valid) begin
            r_out_chans <= r_s1_chans;
            r_out_pwm   <= w_pwm;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(OUT_W-CHAN_BITS-PWM_W)'(0), r_out_pwm, r_out_chans};

`ifndef SYNTHESIS
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_index < IDX_W'(FRAME_BYTES))
        else $error("byte index out of frame range");

    a_idle_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_frame |-> (r_byte_index == '0))
        else $error("byte index nonzero while idle");

    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_last_pos) |=> !r_in_frame)
        else $error("framer did not return to idle after last byte");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !i_m_axis_tready) |=> r_s1_valid)
        else $error("pending result lost while output stalled");
`endif

endmodule

// ===== dv/tb_sbus_frame_decoder_to_pwm_top.sv =====
// Self-checking testbench for sbus_frame_decoder_to_pwm_top: drives bytes, writes config registers
// and checks decoded channels and PWM compare values against a built-in frame decoder model.
// Depends on sbfd_pkg and the design sources.
module tb_sbus_frame_decoder_to_pwm_top;
    import sbfd_pkg::*;

    localparam int PAD_W = OUT_W - CHAN_BITS - PWM_W;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_BYTES = 250;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP = 2'd3;

    typedef struct packed {
        logic [CHAN_COUNT-1:0][CHAN_W-1:0] chans;
        logic [PWM_W-1:0]                  pwm;
    } t_frame_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [7:0]           i_s_axis_tdata = 8'h00;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [OUT_W-1:0]     o_m_axis_tdata;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = REG_DUTY_GAIN;
    logic [15:0]          i_cfg_data = 16'h0000;

    t_frame_result pending_frames[$];
    logic [7:0]    rx_frame [FRAME_BYTES];
    logic [7:0]    tx_frame [FRAME_BYTES];
    logic [4:0]    rx_index = '0;
    bit            rx_in_frame = 1'b0;
    logic [15:0]   duty_gain_q = GAIN_RESET;
    logic [15:0]   pulse_offset_q = OFFSET_RESET;
    bit            steady_flow = 1'b0;
    int            used_bytes = 0;
    int            checked_frames = 0;
    int            reg_writes = 0;
    int            mismatches = 0;
    int            cycle_count = 0;

    sbus_frame_decoder_to_pwm_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_m_axis_tready <= steady_flow || ($urandom_range(99) >= 23);
    end

    // Tracks the framer and returns whether the byte took part in a frame.
    function automatic bit decode_frame_byte(input logic [7:0] b);
        logic [CELL_COUNT*8-1:0] bits;
        logic [PROD_W-1:0]       prod;
        logic [PWM_W:0]          sum;
        t_frame_result           res;
        if (!rx_in_frame) begin
            if (b != START_CODE) return 1'b0;
            rx_in_frame = 1'b1;
            rx_index = '0;
        end
        rx_frame[rx_index] = b;
        rx_index = rx_index + 5'd1;
        if (rx_index < FRAME_BYTES) return 1'b1;
        rx_index = '0;
        rx_in_frame = 1'b0;
        if (rx_frame[FRAME_BYTES-1][3:0] != END_NIBBLE) return 1'b1;
        for (int i = 0; i < CELL_COUNT; i++) bits[i*8 +: 8] = rx_frame[i+1];
        for (int k = 0; k < CHAN_COUNT; k++) res.chans[k] = bits[k*CHAN_W +: CHAN_W];
        prod = res.chans[0] * duty_gain_q;
        sum = {1'b0, pulse_offset_q} + (PWM_W+1)'(prod >> FRAC_BITS);
        res.pwm = sum[PWM_W] ? {PWM_W{1'b1}} : sum[PWM_W-1:0];
        pending_frames.push_back(res);
        return 1'b1;
    endfunction

    always @(negedge i_clk) begin : check_result
        t_frame_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_frames.size() == 0) begin
                $error("unexpected result, tdata %h", o_m_axis_tdata);
                mismatches++;
            end else begin
                want = pending_frames.pop_front();
                checked_frames++;
                for (int k = 0; k < CHAN_COUNT; k++) begin
                    if (o_m_axis_tdata[k*CHAN_W +: CHAN_W] != want.chans[k]) begin
                        $error("chan%0d expected %0d got %0d", k, want.chans[k],
                               o_m_axis_tdata[k*CHAN_W +: CHAN_W]);
                        mismatches++;
                    end
                end
                if (o_m_axis_tdata[CHAN_BITS +: PWM_W] != want.pwm) begin
                    $error("pwm_compare expected %0d got %0d", want.pwm,
                           o_m_axis_tdata[CHAN_BITS +: PWM_W]);
                    mismatches++;
                end
                if (o_m_axis_tdata[OUT_W-1 -: PAD_W] != '0) begin
                    $error("padding expected 0 got %0d", o_m_axis_tdata[OUT_W-1 -: PAD_W]);
                    mismatches++;
                end
            end
        end
    end

    // Each task is entered and left at a rising edge with no pending request change.
    task automatic push_byte(input logic [7:0] b);
        while (!steady_flow && $urandom_range(99) < 23) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= b;
        do @(negedge i_clk); while (!o_s_axis_tready);
        @(posedge i_clk);
        if (decode_frame_byte(b)) used_bytes++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(negedge i_clk); while (!o_cfg_ready);
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        reg_writes++;
        if (idx == REG_DUTY_GAIN) duty_gain_q = val;
        else if (idx == REG_PULSE_OFFSET) pulse_offset_q = val;
        @(posedge i_clk);
    endtask

    task automatic wait_for_quiet();
        i_s_axis_tvalid <= 1'b0;
        while (pending_frames.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic build_frame(input logic [7:0] body, input bit rand_body,
                               input logic [7:0] tail);
        tx_frame[0] = START_CODE;
        for (int i = 1; i < FRAME_BYTES - 1; i++)
            tx_frame[i] = rand_body ? 8'($urandom_range(255)) : body;
        tx_frame[FRAME_BYTES-1] = tail;
    endtask

    task automatic send_frame();
        for (int i = 0; i < FRAME_BYTES; i++) push_byte(tx_frame[i]);
    endtask

    task automatic test_idle_noise();
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'h0E);
    endtask

    task automatic test_channel_extremes();
        build_frame(8'hFF, 1'b0, {4'h0, END_NIBBLE});
        send_frame();
        build_frame(8'h00, 1'b0, {4'hF, END_NIBBLE});
        send_frame();
    endtask

    task automatic test_start_code_in_data();
        build_frame(START_CODE, 1'b0, {4'hA, END_NIBBLE});
        send_frame();
    endtask

    task automatic test_bad_end_nibble();
        build_frame(8'h00, 1'b1, 8'h05);
        send_frame();
        build_frame(8'h00, 1'b1, {END_NIBBLE, 4'h0});
        send_frame();
    endtask

    task automatic test_compare_saturation();
        wait_for_quiet();
        write_reg(REG_DUTY_GAIN, 16'hFFFF);
        write_reg(REG_PULSE_OFFSET, 16'hFFFF);
        build_frame(8'hFF, 1'b0, {4'h5, END_NIBBLE});
        send_frame();
        wait_for_quiet();
        write_reg(REG_DUTY_GAIN, 16'h0000);
        write_reg(REG_PULSE_OFFSET, 16'h0000);
        build_frame(8'h00, 1'b1, {4'h0, END_NIBBLE});
        send_frame();
    endtask

    task automatic test_spare_index();
        wait_for_quiet();
        write_reg(CFG_IDX_SPARE, 16'hFFFF);
        write_reg(CFG_IDX_TOP, 16'hFFFF);
        build_frame(8'hFF, 1'b0, {4'h3, END_NIBBLE});
        send_frame();
    endtask

    task automatic test_random_traffic(input int phases);
        int          goal;
        int          pick;
        logic [7:0]  tail;
        for (int p = 0; p < phases; p++) begin
            wait_for_quiet();
            case (p)
                0: begin
                    write_reg(REG_DUTY_GAIN, GAIN_RESET);
                    write_reg(REG_PULSE_OFFSET, OFFSET_RESET);
                end
                1: begin
                    write_reg(REG_DUTY_GAIN, 16'hFFFF);
                    write_reg(REG_PULSE_OFFSET, 16'h0000);
                end
                2: begin
                    write_reg(REG_DUTY_GAIN, 16'h0000);
                    write_reg(REG_PULSE_OFFSET, 16'hFFFF);
                end
                default: begin
                    write_reg(REG_DUTY_GAIN, 16'($urandom_range(65535)));
                    write_reg(REG_PULSE_OFFSET, 16'($urandom_range(65535)));
                end
            endcase
            write_reg($urandom_range(1) ? CFG_IDX_SPARE : CFG_IDX_TOP,
                      16'($urandom_range(65535)));
            steady_flow = (p == 2);
            goal = used_bytes + PHASE_BYTES;
            while (used_bytes < goal) begin
                pick = $urandom_range(99);
                if (pick < 80) begin
                    tail = {4'($urandom_range(15)), END_NIBBLE};
                    build_frame(8'h00, 1'b1, tail);
                    send_frame();
                end else if (pick < 90) begin
                    tail = 8'($urandom_range(255));
                    if (tail[3:0] == END_NIBBLE) tail[3:0] = ~END_NIBBLE;
                    build_frame(8'h00, 1'b1, tail);
                    send_frame();
                end else begin
                    repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(255)));
                end
            end
            steady_flow = 1'b0;
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_idle_noise();
        test_channel_extremes();
        test_start_code_in_data();
        test_bad_end_nibble();
        test_compare_saturation();
        test_spare_index();
        test_random_traffic(6);
        wait_for_quiet();
        $display("Sent %0d frame bytes and checked %0d decoded frames,", used_bytes,
                 checked_frames);
        $display("with %0d register writes across gain and offset extremes.", reg_writes);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
